// ----- rtl/core/gcov_pkg.sv -----
// Shared types and constants for the Gaussian covariance pipeline.
`default_nettype none

package gcov_pkg;

	// One Gaussian on the input side: quaternion in Q1.14 and axis scales in Q4.12.
	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic        [15:0] scale_a;
		logic        [15:0] scale_b;
		logic        [15:0] scale_c;
	} gcov_gauss_t;

	// Upper triangle of the covariance, signed Q15.24.
	typedef struct packed {
		logic signed [39:0] cov_00;
		logic signed [39:0] cov_01;
		logic signed [39:0] cov_02;
		logic signed [39:0] cov_11;
		logic signed [39:0] cov_12;
		logic signed [39:0] cov_22;
	} gcov_cov_t;

	// Widths of the internal terms.
	localparam int unsigned QP_W  = 32;  // quaternion products, 28 fraction bits
	localparam int unsigned R_W   = 34;  // rotation entries, 28 fraction bits
	localparam int unsigned MP_W  = 51;  // rotation entry times scale
	localparam int unsigned M_W   = 31;  // scaled entries, 20 fraction bits
	localparam int unsigned SP_W  = 62;  // products of scaled entries
	localparam int unsigned SS_W  = 64;  // sum of three products
	localparam int unsigned SR_W  = 48;  // rounded sum, 24 fraction bits
	localparam int unsigned OUT_W = 40;

	localparam int unsigned M_DROP   = 20;
	localparam int unsigned SIG_DROP = 16;

	// 1.0 with 28 fraction bits.
	localparam logic signed [R_W-1:0] R_ONE = R_W'(64'sd268435456);

	// Half an output LSB at each rounding point.
	localparam logic signed [MP_W-1:0] M_HALF   = MP_W'(64'sd524288);
	localparam logic signed [SS_W-1:0] SIG_HALF = SS_W'(64'sd32768);

	localparam logic signed [OUT_W-1:0] COV_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [OUT_W-1:0] COV_MIN = 40'sh80_0000_0000;

	// Column pairs (a, b) of M that form each covariance entry, in output order.
	localparam logic [1:0] COL_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] COL_B [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

endpackage

`default_nettype wire

// ----- rtl/core/gaussian_covariance_from_quat_scale_core.sv -----
// Five-stage pipeline that turns a quaternion and axis scales into a 3D covariance.
`default_nettype none

// Takes one Gaussian per beat and returns the six upper-triangle entries of
// Sigma = M^T M, where M is the rotation matrix of the quaternion with row k
// scaled by scale k. A new item is accepted every cycle unless the output
// stall has backed up into the input. The five register stages are quaternion
// products, rotation entries, scaling, entry products, sum with rounding and
// saturation. The quaternion is used as given, without normalization. When
// the output is stalled the pipeline fills its empty stages first and raises
// its own input stall only once every stage holds an item.
module gaussian_covariance_from_quat_scale_core
	import gcov_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         gauss_valid,
	output logic        gauss_stall,
	input  wire gcov_gauss_t gauss,
	output logic        cov_valid,
	input  wire         cov_stall,
	output gcov_cov_t   cov
);

	// Stage valid bits and enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// A stage loads when it is empty or its content moves on.
	assign en_s5 = !v_s5 || !cov_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign gauss_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= gauss_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: the nine quaternion products, scales carried along.
	logic signed [QP_W-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic        [15:0]     sc_s1 [3];

	always_ff @(posedge clk) begin
		if (en_s1 && gauss_valid) begin
			xx_s1 <= QP_W'(gauss.quat_x) * QP_W'(gauss.quat_x);
			yy_s1 <= QP_W'(gauss.quat_y) * QP_W'(gauss.quat_y);
			zz_s1 <= QP_W'(gauss.quat_z) * QP_W'(gauss.quat_z);
			xy_s1 <= QP_W'(gauss.quat_x) * QP_W'(gauss.quat_y);
			xz_s1 <= QP_W'(gauss.quat_x) * QP_W'(gauss.quat_z);
			yz_s1 <= QP_W'(gauss.quat_y) * QP_W'(gauss.quat_z);
			wx_s1 <= QP_W'(gauss.quat_w) * QP_W'(gauss.quat_x);
			wy_s1 <= QP_W'(gauss.quat_w) * QP_W'(gauss.quat_y);
			wz_s1 <= QP_W'(gauss.quat_w) * QP_W'(gauss.quat_z);
			sc_s1[0] <= gauss.scale_a;
			sc_s1[1] <= gauss.scale_b;
			sc_s1[2] <= gauss.scale_c;
		end
	end

	// Stage 2: rotation matrix entries in row-major order.
	logic signed [R_W-1:0] r_d  [9];
	logic signed [R_W-1:0] r_s2 [9];
	logic        [15:0]    sc_s2 [3];

	always_comb begin
		r_d[0] = R_ONE - ((R_W'(yy_s1) + R_W'(zz_s1)) <<< 1);
		r_d[1] = (R_W'(xy_s1) + R_W'(wz_s1)) <<< 1;
		r_d[2] = (R_W'(xz_s1) - R_W'(wy_s1)) <<< 1;
		r_d[3] = (R_W'(xy_s1) - R_W'(wz_s1)) <<< 1;
		r_d[4] = R_ONE - ((R_W'(xx_s1) + R_W'(zz_s1)) <<< 1);
		r_d[5] = (R_W'(yz_s1) + R_W'(wx_s1)) <<< 1;
		r_d[6] = (R_W'(xz_s1) + R_W'(wy_s1)) <<< 1;
		r_d[7] = (R_W'(yz_s1) - R_W'(wx_s1)) <<< 1;
		r_d[8] = R_ONE - ((R_W'(xx_s1) + R_W'(yy_s1)) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			r_s2  <= r_d;
			sc_s2 <= sc_s1;
		end
	end

	// Stage 3: scale each row and round to 20 fraction bits, half up.
	logic signed [MP_W-1:0] mp_d [9];
	logic signed [M_W-1:0]  m_s3 [9];

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			mp_d[i] = MP_W'(r_s2[i]) * MP_W'($signed({1'b0, sc_s2[i / 3]})) + M_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int i = 0; i < 9; i++) begin
				m_s3[i] <= mp_d[i][MP_W-1:M_DROP];
			end
		end
	end

	// Stage 4: the three row products behind each covariance entry.
	logic signed [SP_W-1:0] p_s4 [6][3];

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int k = 0; k < 6; k++) begin
				for (int row = 0; row < 3; row++) begin
					p_s4[k][row] <= SP_W'(m_s3[3 * row + int'(COL_A[k])])
						* SP_W'(m_s3[3 * row + int'(COL_B[k])]);
				end
			end
		end
	end

	// Stage 5: sum, round to 24 fraction bits and saturate to 40 bits.
	logic signed [SS_W-1:0]  ss_d [6];
	logic signed [SR_W-1:0]  sr_d [6];
	logic signed [OUT_W-1:0] so_d [6];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			ss_d[k] = SS_W'(p_s4[k][0]) + SS_W'(p_s4[k][1]) + SS_W'(p_s4[k][2]) + SIG_HALF;
			sr_d[k] = ss_d[k][SS_W-1:SIG_DROP];
			if (sr_d[k] > SR_W'(COV_MAX)) begin
				so_d[k] = COV_MAX;
			end else if (sr_d[k] < SR_W'(COV_MIN)) begin
				so_d[k] = COV_MIN;
			end else begin
				so_d[k] = sr_d[k][OUT_W-1:0];
			end
		end
	end

	gcov_cov_t cov_s5;

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			cov_s5.cov_00 <= so_d[0];
			cov_s5.cov_01 <= so_d[1];
			cov_s5.cov_02 <= so_d[2];
			cov_s5.cov_11 <= so_d[3];
			cov_s5.cov_12 <= so_d[4];
			cov_s5.cov_22 <= so_d[5];
		end
	end

	assign cov_valid = v_s5;
	assign cov       = cov_s5;

`ifndef ASSERT_OFF
	// The input is held off only when every stage is full and the output waits.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		gauss_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && cov_stall))
		else $error("input stalled while the pipeline had room");

	// An item in stage 4 reaches the output when that stage moves.
	a_s4_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en_s5) |=> cov_valid)
		else $error("item lost between stage 4 and the output");

	// An accepted beat occupies stage 1 in the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(gauss_valid && !gauss_stall) |=> v_s1)
		else $error("accepted beat did not enter stage 1");

	// Diagonal entries are sums of squares and can never be negative.
	a_diag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		cov_valid |-> (!cov.cov_00[OUT_W-1] && !cov.cov_11[OUT_W-1] && !cov.cov_22[OUT_W-1]))
		else $error("negative diagonal covariance entry");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the quaternion-and-scale to 3D covariance pipeline.
`timescale 1ns / 1ps

module tb_top
	import gcov_pkg::*;
();

	// Directed rows: the result is typed in where it is obvious, else predicted.
	typedef struct packed {
		logic        typed;
		gcov_gauss_t gauss_in;
		gcov_cov_t   cov_typed;
	} stim_row_t;

	localparam logic signed [15:0] Q_ONE  = 16'sd16384;
	localparam logic signed [15:0] Q_NEG1 = 16'shC000;
	localparam logic signed [15:0] Q_HRT  = 16'sd11585;
	localparam logic signed [15:0] Q_NHRT = 16'shD2BF;
	localparam logic signed [15:0] Q_MIN  = 16'sh8000;
	localparam logic signed [15:0] Q_MAX  = 16'sh7FFF;
	localparam logic        [15:0] S_ONE  = 16'd4096;
	localparam logic        [15:0] S_MAX  = 16'hFFFF;

	localparam logic signed [39:0] CE_UNIT = 40'sd16777216;
	localparam logic signed [39:0] CE_SMAX = 40'sd4294836225;
	localparam logic signed [39:0] CE_ZERO = 40'sd0;

	localparam gcov_cov_t COV_ZERO = '0;
	localparam gcov_cov_t COV_UNIT = '{CE_UNIT, CE_ZERO, CE_ZERO, CE_UNIT, CE_ZERO, CE_UNIT};
	localparam gcov_cov_t COV_SMAX = '{CE_SMAX, CE_ZERO, CE_ZERO, CE_SMAX, CE_ZERO, CE_SMAX};
	localparam gcov_cov_t COV_SAT  = '{COV_MAX, COV_MIN, COV_MIN, COV_MAX, COV_MIN, COV_MAX};

	localparam int NUM_DIR = 16;

	localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
		// All zero: nothing to scale.
		'{1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 16'd0}, COV_ZERO},
		// Identity rotation with unit scales.
		'{1'b1, '{Q_ONE, 16'sd0, 16'sd0, 16'sd0, S_ONE, S_ONE, S_ONE}, COV_UNIT},
		// Zero quaternion still gives the identity matrix; largest scales.
		'{1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, S_MAX, S_MAX, S_MAX}, COV_SMAX},
		// Most negative quaternion with largest scales saturates every entry.
		'{1'b1, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, S_MAX, S_MAX, S_MAX}, COV_SAT},
		'{1'b0, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, S_MAX, S_MAX, S_MAX}, COV_ZERO},
		'{1'b0, '{Q_ONE, 16'sd0, 16'sd0, 16'sd0, S_MAX, 16'd0, S_ONE}, COV_ZERO},
		// Quarter turns about each axis.
		'{1'b0, '{Q_HRT, Q_HRT, 16'sd0, 16'sd0, 16'd2048, 16'd4096, 16'd8192}, COV_ZERO},
		'{1'b0, '{Q_HRT, 16'sd0, Q_HRT, 16'sd0, S_ONE, S_MAX, 16'd1}, COV_ZERO},
		'{1'b0, '{Q_HRT, 16'sd0, 16'sd0, Q_NHRT, 16'd12288, 16'd2048, 16'd4096}, COV_ZERO},
		// Half turn about x.
		'{1'b0, '{16'sd0, Q_ONE, 16'sd0, 16'sd0, S_ONE, 16'd8192, 16'd3}, COV_ZERO},
		'{1'b0, '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 16'd1000, 16'd2000, 16'd3000},
			COV_ZERO},
		'{1'b0, '{Q_NEG1, 16'sd0, 16'sd0, 16'sd0, 16'd6000, 16'd5, 16'd40000}, COV_ZERO},
		// Quaternions that are far from unit length are used as given.
		'{1'b0, '{Q_MAX, 16'sd0, 16'sd0, 16'sd0, S_ONE, S_ONE, S_ONE}, COV_ZERO},
		'{1'b0, '{16'sd100, 16'shFF38, 16'sd300, 16'shFE70, S_MAX, S_MAX, S_MAX}, COV_ZERO},
		'{1'b0, '{Q_MIN, Q_MAX, 16'shFFFF, 16'sd1, S_MAX, 16'd0, 16'd0}, COV_ZERO},
		// Tiny scales put the rounding steps right at their edges.
		'{1'b0, '{16'sd9459, 16'sd9459, 16'sd9459, 16'sd0, 16'd1, 16'd2, 16'd3}, COV_ZERO}
	};

	logic        clk;
	logic        arst_n;
	logic        gauss_valid;
	logic        gauss_stall;
	gcov_gauss_t gauss;
	logic        cov_valid;
	logic        cov_stall;
	gcov_cov_t   cov;

	gcov_cov_t   pending_cov_q [$];
	gcov_cov_t   cov_head;
	logic        idle_on;
	logic        rx_hold_req;
	int unsigned mismatch_count;
	int unsigned cov_beats;
	int unsigned gauss_sent;
	int unsigned input_stall_cycles;

	gaussian_covariance_from_quat_scale_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.gauss_valid (gauss_valid),
		.gauss_stall (gauss_stall),
		.gauss       (gauss),
		.cov_valid   (cov_valid),
		.cov_stall   (cov_stall),
		.cov         (cov)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Round half up to a Q15.24 entry and clamp to the 40-bit range.
	function automatic logic signed [39:0] round_clamp_q15_24(longint sum_q40);
		longint rounded;
		rounded = (sum_q40 + (longint'(1) << 15)) >>> 16;
		if (rounded > longint'(COV_MAX))
			return COV_MAX;
		if (rounded < longint'(COV_MIN))
			return COV_MIN;
		return rounded[39:0];
	endfunction

	// Covariance of one Gaussian: rotation from the quaternion, rows scaled,
	// then the upper triangle of M^T M.
	function automatic gcov_cov_t covariance_of(gcov_gauss_t g);
		longint qw, qx, qy, qz, unit_q28;
		longint sc [3];
		longint rot [9];
		longint msc [9];
		gcov_cov_t res;
		qw = longint'(g.quat_w);
		qx = longint'(g.quat_x);
		qy = longint'(g.quat_y);
		qz = longint'(g.quat_z);
		sc[0] = longint'(g.scale_a);
		sc[1] = longint'(g.scale_b);
		sc[2] = longint'(g.scale_c);
		unit_q28 = longint'(1) << 28;
		rot[0] = unit_q28 - 2 * (qy * qy + qz * qz);
		rot[1] = 2 * (qx * qy + qw * qz);
		rot[2] = 2 * (qx * qz - qw * qy);
		rot[3] = 2 * (qx * qy - qw * qz);
		rot[4] = unit_q28 - 2 * (qx * qx + qz * qz);
		rot[5] = 2 * (qy * qz + qw * qx);
		rot[6] = 2 * (qx * qz + qw * qy);
		rot[7] = 2 * (qy * qz - qw * qx);
		rot[8] = unit_q28 - 2 * (qx * qx + qy * qy);
		for (int i = 0; i < 9; i++)
			msc[i] = (rot[i] * sc[i / 3] + (longint'(1) << 19)) >>> 20;
		res.cov_00 = round_clamp_q15_24(msc[0] * msc[0] + msc[3] * msc[3] + msc[6] * msc[6]);
		res.cov_01 = round_clamp_q15_24(msc[0] * msc[1] + msc[3] * msc[4] + msc[6] * msc[7]);
		res.cov_02 = round_clamp_q15_24(msc[0] * msc[2] + msc[3] * msc[5] + msc[6] * msc[8]);
		res.cov_11 = round_clamp_q15_24(msc[1] * msc[1] + msc[4] * msc[4] + msc[7] * msc[7]);
		res.cov_12 = round_clamp_q15_24(msc[1] * msc[2] + msc[4] * msc[5] + msc[7] * msc[8]);
		res.cov_22 = round_clamp_q15_24(msc[2] * msc[2] + msc[5] * msc[5] + msc[8] * msc[8]);
		return res;
	endfunction

	// Mostly unit quaternions with plausible scales, plus raw full-range words.
	function automatic gcov_gauss_t random_gauss();
		gcov_gauss_t g;
		int unsigned pick;
		int unsigned scale_mode;
		real comp [4];
		real norm_len;
		pick = $urandom_range(0, 9);
		scale_mode = $urandom_range(0, 3);
		if (pick < 2) begin
			g.quat_w = 16'($urandom);
			g.quat_x = 16'($urandom);
			g.quat_y = 16'($urandom);
			g.quat_z = 16'($urandom);
		end else begin
			for (int k = 0; k < 4; k++)
				comp[k] = real'($urandom_range(0, 32768)) - 16384.0;
			norm_len = $sqrt(comp[0] * comp[0] + comp[1] * comp[1] +
				comp[2] * comp[2] + comp[3] * comp[3]);
			if (norm_len < 1.0) begin
				comp[0] = 1.0;
				norm_len = 1.0;
			end
			g.quat_w = 16'($rtoi(comp[0] * 16384.0 / norm_len));
			g.quat_x = 16'($rtoi(comp[1] * 16384.0 / norm_len));
			g.quat_y = 16'($rtoi(comp[2] * 16384.0 / norm_len));
			g.quat_z = 16'($rtoi(comp[3] * 16384.0 / norm_len));
		end
		if (scale_mode == 0) begin
			g.scale_a = 16'($urandom);
			g.scale_b = 16'($urandom);
			g.scale_c = 16'($urandom);
		end else if (scale_mode == 1) begin
			g.scale_a = 16'($urandom_range(0, 15));
			g.scale_b = 16'($urandom_range(0, 15));
			g.scale_c = 16'($urandom_range(0, 15));
		end else begin
			g.scale_a = 16'($urandom_range(0, 8191));
			g.scale_b = 16'($urandom_range(0, 8191));
			g.scale_c = 16'($urandom_range(0, 8191));
		end
		return g;
	endfunction

	// Offer one Gaussian, after a random gap when idling is on, and record its covariance once accepted.
	task automatic send_gauss(gcov_gauss_t g, logic typed, gcov_cov_t typed_cov);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			gauss_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		gauss_valid <= 1'b1;
		gauss <= g;
		do @(posedge clk); while (gauss_stall);
		pending_cov_q.insert(pending_cov_q.size(), typed ? typed_cov : covariance_of(g));
		gauss_sent++;
		@(negedge clk);
	endtask

	// Hold the input quiet until every outstanding covariance has come back.
	task automatic drain_results();
		gauss_valid <= 1'b0;
		@(negedge clk);
		while (pending_cov_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_random(int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_gauss(random_gauss(), 1'b0, COV_ZERO);
	endtask

	task automatic check_entry(string name, logic signed [39:0] want,
		logic signed [39:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each accepted covariance beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && gauss_valid && gauss_stall)
			input_stall_cycles++;
		if (arst_n && cov_valid && !cov_stall) begin
			cov_beats++;
			if (pending_cov_q.size() == 0) begin
				$error("covariance beat with no Gaussian outstanding");
				mismatch_count++;
			end else begin
				cov_head = pending_cov_q.pop_front();
				check_entry("cov_00", cov_head.cov_00, cov.cov_00);
				check_entry("cov_01", cov_head.cov_01, cov.cov_01);
				check_entry("cov_02", cov_head.cov_02, cov.cov_02);
				check_entry("cov_11", cov_head.cov_11, cov.cov_11);
				check_entry("cov_12", cov_head.cov_12, cov.cov_12);
				check_entry("cov_22", cov_head.cov_22, cov.cov_22);
			end
		end
	end

	// Output side: stall for a drawn number of cycles before each beat, or for a
	// long stretch when asked, so the pipeline fills and pushes back.
	initial begin
		int unsigned hold_cycles;
		cov_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				hold_cycles = 40;
				rx_hold_req = 1'b0;
			end else begin
				hold_cycles = idle_on ? $urandom_range(0, 4) : 0;
			end
			if (hold_cycles > 0) begin
				cov_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
			end
			cov_stall <= 1'b0;
			do @(posedge clk); while (!cov_valid);
			@(negedge clk);
		end
	end

	// Main sequence: reset, directed table, then random phases with and without idling.
	initial begin
		arst_n = 1'b0;
		gauss_valid = 1'b0;
		gauss = '0;
		idle_on = 1'b1;
		rx_hold_req = 1'b0;
		mismatch_count = 0;
		cov_beats = 0;
		gauss_sent = 0;
		input_stall_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIR_ROWS[i])
			send_gauss(DIR_ROWS[i].gauss_in, DIR_ROWS[i].typed, DIR_ROWS[i].cov_typed);
		drain_results();

		// Back-to-back input against a long output stall.
		idle_on = 1'b0;
		rx_hold_req = 1'b1;
		send_random(40);
		idle_on = 1'b1;
		send_random(230);
		drain_results();

		idle_on = 1'b0;
		send_random(100);
		idle_on = 1'b1;
		send_random(130);
		drain_results();
		repeat (10) @(posedge clk);

		$display("Sent %0d Gaussians (%0d directed), checked %0d covariance beats.",
			gauss_sent, NUM_DIR, cov_beats);
		$display("Input held off for %0d cycles by output back-pressure; %0d mismatches.",
			input_stall_cycles, mismatch_count);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("Timeout with %0d covariance beats outstanding.", pending_cov_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
